// ===== rtl/ltrap_pkg.sv =====
// Shared types and constants for the limited trapezoidal integrator.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package ltrap_pkg;

  localparam int unsigned DataWidth       = 32;
  localparam int unsigned AccWidthDefault = 48;

  // Register reset values, signed Q16.16
  localparam logic [DataWidth-1:0] GainReset  = 32'h0001_0000;
  localparam logic [DataWidth-1:0] UpperReset = 32'h7FFF_FFFF;
  localparam logic [DataWidth-1:0] LowerReset = 32'h8000_0000;

  localparam int unsigned CfgAddrWidth = 2;

  typedef enum logic [CfgAddrWidth-1:0] {
    RegGain  = 2'd0,
    RegUpper = 2'd1,
    RegLower = 2'd2
  } reg_idx_e;

  // gain*(s)*dt is at most 2^95; the scale 2^16*2000 splits into 2^20 * 125
  localparam int unsigned ProdWidth    = 96;
  localparam int unsigned FracBits     = 20;
  localparam int unsigned DivWidth     = 80;
  localparam int unsigned DivRadixBits = 8;
  localparam int unsigned DivSteps     = DivWidth / DivRadixBits;
  localparam int unsigned DivCntWidth  = $clog2(DivSteps);
  localparam int unsigned RemWidth     = 7;
  localparam logic [RemWidth:0] DivConst = 8'd125;

  typedef struct packed {
    logic signed [DataWidth-1:0] sample;
    logic                        enable;
    logic                        clear;
    logic [DataWidth-1:0]        now_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] integral;
    logic                        limited;
  } out_word_t;

  // One strobe per sequencer step, to the datapath and the top level
  typedef struct packed {
    logic load;
    logic mul_p;
    logic mul_lo;
    logic mul_hi;
    logic div;
    logic acc;
    logic clamp;
    logic commit;
    logic zero;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/limited_trapezoidal_integrator_top.sv =====
// Top level of the limited trapezoidal integrator: ports, registers, input and output words.
// Depends on ltrap_pkg, ltrap_seq and ltrap_dp.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_we_i                cfg_addr_i, cfg_wdata_i
//   in       in         in_valid_i/in_ready_o   in_data_i  (sample, enable, clear, now_ms)
//   out      out        out_valid_o/out_ready_i out_data_o (integral, limited)
//
// An enabled word after the first keeps in_ready_o low from its acceptance through one operand
// load, three passes through the shared 33x32 multiplier, the 8-bit-per-cycle divide-by-125
// unit, one accumulate, one clamp, then the hand-off. A word that only records or holds goes
// from its acceptance straight to the hand-off.
// Reset clears the registers, the state and the output valid at once; there is no sweep.
// A result waits in the output register while the next word is worked on; that word's
// hand-off then holds, and in_ready_o stays low, until out_ready_i frees the register.
`default_nettype none

module limited_trapezoidal_integrator_top #(
  parameter int unsigned AccWidth = ltrap_pkg::AccWidthDefault
) (
  input  var logic                                clk_i,
  input  var logic                                rst_ni,
  input  var logic                                cfg_we_i,
  input  var logic [ltrap_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  var logic [ltrap_pkg::DataWidth-1:0]     cfg_wdata_i,
  input  var logic                                in_valid_i,
  output logic                                    in_ready_o,
  input  var ltrap_pkg::in_word_t                 in_data_i,
  output logic                                    out_valid_o,
  input  var logic                                out_ready_i,
  output ltrap_pkg::out_word_t                    out_data_o
);

  // configuration
  logic [31:0] gain_q, upper_q, lower_q;

  // captured word and integrator history
  ltrap_pkg::in_word_t  item_q;
  logic                 started_q;
  logic [31:0]          prev_sample_q;
  logic [31:0]          prev_time_q;
  logic [31:0]          dt;

  // output register
  logic                 out_valid_q;
  ltrap_pkg::out_word_t out_data_q;
  logic                 out_free;

  ltrap_pkg::ctrl_t     ctrl;
  logic                 in_accept;
  logic [31:0]          held_integral;
  logic                 held_limited;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign dt        = item_q.now_ms - prev_time_q;   // wraps modulo 2^32

  // register writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= ltrap_pkg::GainReset;
      upper_q <= ltrap_pkg::UpperReset;
      lower_q <= ltrap_pkg::LowerReset;
    end else if (cfg_we_i) begin
      unique case (ltrap_pkg::reg_idx_e'(cfg_addr_i))
        ltrap_pkg::RegGain:  gain_q  <= cfg_wdata_i;
        ltrap_pkg::RegUpper: upper_q <= cfg_wdata_i;
        ltrap_pkg::RegLower: lower_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // capture the word; it stays put until the hand-off
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
  end

  // History: the first word always records its sample; a clear leaves both
  // the previous sample and the previous time untouched otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      prev_sample_q <= '0;
      prev_time_q   <= '0;
    end else if (ctrl.commit) begin
      started_q <= 1'b1;
      if (!started_q || !item_q.clear) begin
        prev_sample_q <= item_q.sample;
      end
      if (!item_q.clear) begin
        prev_time_q <= item_q.now_ms;
      end
    end
  end

  ltrap_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .integrate_i (started_q && in_data_i.enable),
    .clear_i     (item_q.clear),
    .out_free_i  (out_free),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  ltrap_dp #(
    .AccWidth (AccWidth)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .gain_i        (gain_q),
    .upper_i       (upper_q),
    .lower_i       (lower_q),
    .sample_i      (item_q.sample),
    .prev_sample_i (prev_sample_q),
    .dt_i          (dt),
    .integral_o    (held_integral),
    .limited_o     (held_limited)
  );

  // Load the result at the hand-off; a clear word shows zero and no limit,
  // the same values the datapath takes on at that edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_data_q.integral <= item_q.clear ? '0 : held_integral;
      out_data_q.limited  <= item_q.clear ? 1'b0 : held_limited;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/ltrap_seq.sv =====
// Step sequencer of the limited trapezoidal integrator.
// Depends on ltrap_pkg (ctrl_t, DivSteps, DivCntWidth).
`default_nettype none

module ltrap_seq (
  input  var logic           clk_i,
  input  var logic           rst_ni,
  input  var logic           in_valid_i,
  input  var logic           integrate_i,
  input  var logic           clear_i,
  input  var logic           out_free_i,
  output logic               in_ready_o,
  output ltrap_pkg::ctrl_t   ctrl_o
);

  localparam int unsigned CntW = ltrap_pkg::DivCntWidth;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StLoad  = 9'b000000010,
    StMulP  = 9'b000000100,
    StMulLo = 9'b000001000,
    StMulHi = 9'b000010000,
    StDiv   = 9'b000100000,
    StAcc   = 9'b001000000,
    StClamp = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            div_last;

  assign div_last = (cnt_q == CntW'(ltrap_pkg::DivSteps - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = integrate_i ? StLoad : StDone;
        end
      end
      StLoad:  state_d = StMulP;
      StMulP:  state_d = StMulLo;
      StMulLo: state_d = StMulHi;
      StMulHi: begin
        state_d = StDiv;
        cnt_d   = '0;
      end
      StDiv: begin
        cnt_d = cnt_q + CntW'(1);
        if (div_last) begin
          state_d = StAcc;
        end
      end
      StAcc:   state_d = StClamp;
      StClamp: state_d = StDone;
      StDone: begin
        // hold until the output register can take the word
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign ctrl_o.load   = (state_q == StLoad);
  assign ctrl_o.mul_p  = (state_q == StMulP);
  assign ctrl_o.mul_lo = (state_q == StMulLo);
  assign ctrl_o.mul_hi = (state_q == StMulHi);
  assign ctrl_o.div    = (state_q == StDiv);
  assign ctrl_o.acc    = (state_q == StAcc);
  assign ctrl_o.clamp  = (state_q == StClamp);
  assign ctrl_o.commit = (state_q == StDone) && out_free_i;
  assign ctrl_o.zero   = (state_q == StDone) && out_free_i && clear_i;

endmodule

`default_nettype wire

// ===== rtl/ltrap_dp.sv =====
// Arithmetic datapath: shared multiplier, divide-by-125 unit, accumulator and clamp.
// Depends on ltrap_pkg (ctrl_t and the divider constants).
`default_nettype none

module ltrap_dp #(
  parameter int unsigned AccWidth = ltrap_pkg::AccWidthDefault
) (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var ltrap_pkg::ctrl_t ctrl_i,
  input  var logic [31:0]      gain_i,
  input  var logic [31:0]      upper_i,
  input  var logic [31:0]      lower_i,
  input  var logic [31:0]      sample_i,
  input  var logic [31:0]      prev_sample_i,
  input  var logic [31:0]      dt_i,
  output logic [31:0]          integral_o,
  output logic                 limited_o
);

  localparam int unsigned PW  = ltrap_pkg::ProdWidth;
  localparam int unsigned FB  = ltrap_pkg::FracBits;
  localparam int unsigned DW  = ltrap_pkg::DivWidth;
  localparam int unsigned RW  = ltrap_pkg::RemWidth;
  localparam logic signed [AccWidth-1:0] MaxV = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic signed [AccWidth-1:0] MinV = {1'b1, {(AccWidth-1){1'b0}}};

  // operand magnitudes and result sign
  logic [31:0]   mag_g_q;
  logic [32:0]   mag_s_q;
  logic          neg_q;
  logic [32:0]   s_sum;

  // shared multiplier
  logic [32:0]   mul_a;
  logic [31:0]   mul_b;
  logic [64:0]   mul_res;
  logic [63:0]   p_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] prod_sum;

  // divider
  logic [DW-1:0] div_q, div_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW:0]   trial;
  logic          frac_q;

  // accumulator update
  logic [DW-1:0]         q_full;
  logic                  q_big;
  logic [AccWidth+1:0]   acc_ext, q_ext, acc_sum;
  logic                  acc_ovf;
  logic signed [AccWidth-1:0] acc_q, acc_new;
  logic signed [AccWidth-1:0] up_ext, dn_ext;

  logic [31:0]   held_q;
  logic          held_lim_q;

  assign s_sum = {sample_i[31], sample_i} + {prev_sample_i[31], prev_sample_i};

  always_comb begin
    if (ctrl_i.mul_p) begin
      mul_a = mag_s_q;
      mul_b = mag_g_q;
    end else if (ctrl_i.mul_lo) begin
      mul_a = {1'b0, p_q[31:0]};
      mul_b = dt_i;
    end else begin
      mul_a = {1'b0, p_q[63:32]};
      mul_b = dt_i;
    end
  end

  assign mul_res  = mul_a * mul_b;
  assign prod_sum = prod_q + {mul_res[63:0], 32'h0};

  // eight restoring steps per cycle, quotient bits shift in from the bottom
  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < ltrap_pkg::DivRadixBits; i++) begin
      trial = {rem_d, div_d[DW-1]};
      div_d = {div_d[DW-2:0], 1'b0};
      if (trial >= ltrap_pkg::DivConst) begin
        rem_d    = RW'(trial - ltrap_pkg::DivConst);
        div_d[0] = 1'b1;
      end else begin
        rem_d = trial[RW-1:0];
      end
    end
  end

  // floor: a negative increment with any dropped fraction grows by one
  assign q_full  = div_q + DW'(neg_q && (frac_q || (rem_q != '0)));
  assign q_big   = |q_full[DW-1:AccWidth];
  assign acc_ext = {{2{acc_q[AccWidth-1]}}, acc_q};
  assign q_ext   = {2'b00, q_full[AccWidth-1:0]};
  assign acc_sum = neg_q ? (acc_ext - q_ext) : (acc_ext + q_ext);
  assign acc_ovf = (acc_sum[AccWidth+1:AccWidth-1] != 3'b000) &&
                   (acc_sum[AccWidth+1:AccWidth-1] != 3'b111);
  assign acc_new = (q_big || acc_ovf) ? (neg_q ? MinV : MaxV)
                                      : acc_sum[AccWidth-1:0];

  assign up_ext = {{(AccWidth-32){upper_i[31]}}, upper_i};
  assign dn_ext = {{(AccWidth-32){lower_i[31]}}, lower_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mag_g_q <= gain_i[31] ? (32'd0 - gain_i) : gain_i;
      mag_s_q <= s_sum[32] ? (33'd0 - s_sum) : s_sum;
      neg_q   <= gain_i[31] ^ s_sum[32];
    end
    if (ctrl_i.mul_p) begin
      p_q <= mul_res[63:0];
    end
    if (ctrl_i.mul_lo) begin
      prod_q <= {32'h0, mul_res[63:0]};
    end
    if (ctrl_i.mul_hi) begin
      div_q  <= DW'(prod_sum[PW-1:FB]);
      rem_q  <= '0;
      frac_q <= |prod_q[FB-1:0];
    end else if (ctrl_i.div) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      held_q     <= '0;
      held_lim_q <= 1'b0;
    end else begin
      if (ctrl_i.zero) begin
        acc_q      <= '0;
        held_q     <= '0;
        held_lim_q <= 1'b0;
      end else if (ctrl_i.acc) begin
        acc_q <= acc_new;
      end else if (ctrl_i.clamp) begin
        // upper test first so crossed limits resolve to the upper one
        if (acc_q >= up_ext) begin
          held_q     <= upper_i;
          held_lim_q <= 1'b1;
        end else if (acc_q <= dn_ext) begin
          held_q     <= lower_i;
          held_lim_q <= 1'b1;
        end else begin
          held_q     <= acc_q[31:0];
          held_lim_q <= 1'b0;
        end
      end
    end
  end

  assign integral_o = held_q;
  assign limited_o  = held_lim_q;

endmodule

`default_nettype wire

// ===== rtl/ltrap_checker.sv =====
// Port-level checks for the limited trapezoidal integrator, bound to the top level.
// Depends on ltrap_pkg (out_word_t) and limited_trapezoidal_integrator_top.
`default_nettype none

module ltrap_checker (
  input var logic                 clk_i,
  input var logic                 rst_ni,
  input var logic                 in_valid_i,
  input var logic                 in_ready_o,
  input var logic                 out_valid_o,
  input var logic                 out_ready_i,
  input var ltrap_pkg::out_word_t out_data_o
);

  // words taken in but not yet delivered
  logic [1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed or dropped while stalled");

  // the block is busy right after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted word");

  // one word in the output register and one in work at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words outstanding");

  // no result without a word behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("output valid with no word outstanding");

endmodule

bind limited_trapezoidal_integrator_top ltrap_checker u_ltrap_checker (.*);

`default_nettype wire

// ===== bench/tb_limited_trapezoidal_integrator_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for limited_trapezoidal_integrator_top: a directed table, then random phases.
// Depends on ltrap_pkg and the top level; an in-bench integrator predicts every output word.

module tb_limited_trapezoidal_integrator_top;
  import ltrap_pkg::*;

  localparam int AccW = AccWidthDefault;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [CfgAddrWidth-1:0] RegSpare = 2'd3;
  // Q16.16 gain times a millisecond dt over 2000: divide the raw product by 2^16 * 2000
  localparam logic signed [127:0] ScaleDiv = 128'sd131072000;
  localparam logic signed [127:0] AccTop = (128'sd1 <<< (AccW - 1)) - 128'sd1;
  localparam logic signed [127:0] AccBot = -AccTop - 128'sd1;
  localparam int RandPhases = 11;
  localparam int WordsPerPhase = 148;
  localparam int MaxGap = 18;
  // Leave room past the time an enabled word keeps the block busy
  localparam int TailCycles = 40;

  // Bench-side signals, all known from time zero
  logic                    clk_i = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr = RegGain;
  logic [DataWidth-1:0]    cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_word_t                in_word = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_word_t               out_word;

  // Predicted integrator: registers and state as they stand after reset
  logic signed [DataWidth-1:0] gain_q = GainReset;
  logic signed [DataWidth-1:0] upper_q = UpperReset;
  logic signed [DataWidth-1:0] lower_q = LowerReset;
  logic                        started_q = 1'b0;
  logic signed [AccW-1:0]      acc_q = '0;
  logic signed [DataWidth-1:0] prev_sample_q = '0;
  logic [DataWidth-1:0]        prev_time_q = '0;
  out_word_t                   held_q = '0;

  // Output words still owed by the block, oldest first
  out_word_t pending_outputs[$];

  // Zero turns idling off on both sides; otherwise a burst starts with odds 1 in (idle_odds+1)
  int unsigned idle_odds = 0;
  int unsigned n_fail = 0;
  int unsigned n_words = 0;
  int unsigned n_checked = 0;
  int unsigned n_limited = 0;
  int unsigned n_writes = 0;

  // One step of the directed table: a register write or an input word
  typedef struct {
    bit                      is_reg;
    logic [CfgAddrWidth-1:0] reg_idx;
    logic [DataWidth-1:0]    reg_val;
    in_word_t                word;
    bit                      typed;
    out_word_t               want;
  } table_row_t;

  table_row_t directed[$];

  limited_trapezoidal_integrator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  // Add one trapezoid to the accumulator, then clamp it to the output limits.
  // Work in 128 bits: |gain * (s0 + s1) * dt| stays below 2^96.
  function automatic void accumulate_trapezoid(logic signed [DataWidth-1:0] sample,
                                               logic [DataWidth-1:0] dt);
    logic signed [127:0] g, s, d, area, step, acc, lim_hi, lim_lo;
    g = gain_q;
    s = sample;
    s = s + prev_sample_q;
    d = {96'd0, dt};
    area = g * s * d;
    // Division truncates toward zero; pull inexact negative quotients down one
    step = area / ScaleDiv;
    if (area < 0 && area % ScaleDiv != 0) step = step - 1;
    acc = acc_q;
    acc = acc + step;
    // Saturate at the accumulator's own width, not at the limits
    if (acc > AccTop) acc = AccTop;
    else if (acc < AccBot) acc = AccBot;
    acc_q = acc[AccW-1:0];
    // Test the upper limit first so crossed limits resolve the same way as the block
    lim_hi = upper_q;
    lim_lo = lower_q;
    if (acc >= lim_hi) begin
      held_q.integral = upper_q;
      held_q.limited = 1'b1;
    end else if (acc <= lim_lo) begin
      held_q.integral = lower_q;
      held_q.limited = 1'b1;
    end else begin
      held_q.integral = acc[DataWidth-1:0];
      held_q.limited = 1'b0;
    end
  endfunction

  // Advance the predicted state by one accepted word and return the output it yields
  function automatic out_word_t advance_integrator(in_word_t w);
    if (!started_q) begin
      // First word only records the sample
      started_q = 1'b1;
      prev_sample_q = w.sample;
    end else if (w.enable) begin
      accumulate_trapezoid(w.sample, w.now_ms - prev_time_q);
    end
    if (w.clear) begin
      // Clear wins over this word's update and keeps the previous sample and time
      acc_q = '0;
      held_q = '0;
    end else begin
      prev_sample_q = w.sample;
      prev_time_q = w.now_ms;
    end
    return held_q;
  endfunction

  function automatic table_row_t word_row(logic [DataWidth-1:0] sample, logic enable,
                                          logic clear, logic [DataWidth-1:0] now_ms);
    table_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = RegGain;
    r.reg_val = '0;
    r.word.sample = sample;
    r.word.enable = enable;
    r.word.clear = clear;
    r.word.now_ms = now_ms;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // Word row whose output is written down by hand instead of predicted
  function automatic table_row_t fixed_row(logic [DataWidth-1:0] sample, logic enable,
                                           logic clear, logic [DataWidth-1:0] now_ms,
                                           logic [DataWidth-1:0] integral, logic limited);
    table_row_t r;
    r = word_row(sample, enable, clear, now_ms);
    r.typed = 1'b1;
    r.want.integral = integral;
    r.want.limited = limited;
    return r;
  endfunction

  function automatic table_row_t reg_row(logic [CfgAddrWidth-1:0] idx,
                                         logic [DataWidth-1:0] val);
    table_row_t r;
    r = word_row('0, 1'b0, 1'b0, '0);
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Random word from a mostly steady clock: small steps, some zero dt, jumps and wraps
  function automatic in_word_t next_word(inout logic [DataWidth-1:0] t_ms);
    in_word_t          w;
    int unsigned       pick;
    logic [DataWidth-1:0] mag;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: w.sample = 32'h7FFF_FFFF;
        1: w.sample = 32'h8000_0000;
        2: w.sample = '0;
        default: w.sample = '1;
      endcase
    end else if (pick < 40) begin
      w.sample = $urandom;
    end else begin
      mag = $urandom & ((32'd1 << $urandom_range(4, 24)) - 32'd1);
      w.sample = $urandom_range(0, 1) ? -mag : mag;
    end
    pick = $urandom_range(0, 99);
    if (pick >= 96) t_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);  // walk across the wrap
    else if (pick >= 91) t_ms = $urandom;                         // jump, backward too
    else if (pick >= 6) t_ms = t_ms + $urandom_range(1, 20);
    // otherwise stay on the same millisecond: zero dt
    w.now_ms = t_ms;
    w.enable = ($urandom_range(0, 99) < 88);
    w.clear = ($urandom_range(0, 99) < 4);
    return w;
  endfunction

  // Present one word, hold it until taken, then log what it should produce
  task automatic push_word(input in_word_t w, input bit typed, input out_word_t want);
    int unsigned gap;
    out_word_t   got;
    gap = (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) ? $urandom_range(1, MaxGap) : 0;
    cfg_we <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready);
    // Accepted at this edge; keep the predictor in step even for hand-typed rows
    got = advance_integrator(w);
    pending_outputs.push_back(typed ? want : got);
    n_words++;
  endtask

  // Drop valid and hold until every owed word has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_outputs.size() != 0);
  endtask

  task automatic set_reg(input logic [CfgAddrWidth-1:0] idx, input logic [DataWidth-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      RegGain:  gain_q = val;
      RegUpper: upper_q = val;
      RegLower: lower_q = val;
      default: ;
    endcase
    n_writes++;
  endtask

  // Receiver: stall in random bursts while idling is on, otherwise always ready
  initial begin : sink_stalls
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) hold--;
      else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
        hold = $urandom_range(1, MaxGap);
      out_ready <= (hold == 0);
    end
  end

  // Compare each word taken from the block against the oldest prediction
  always @(posedge clk_i) begin : check_outputs
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("output word with none expected: integral %h limited %b",
               out_word.integral, out_word.limited);
        n_fail++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_word.integral !== want.integral) begin
          $error("integral: expected %h, actual %h", want.integral, out_word.integral);
          n_fail++;
        end
        if (out_word.limited !== want.limited) begin
          $error("limited: expected %b, actual %b", want.limited, out_word.limited);
          n_fail++;
        end
        n_checked++;
        if (out_word.limited === 1'b1) n_limited++;
      end
    end
  end

  initial begin : stimulus
    logic [DataWidth-1:0] g, u, l, m, t_ms;

    // Default limits and unit gain: the first rows can be worked out by hand.
    // First word carries clear: it records the sample, zeroes, and keeps time at zero.
    directed.push_back(fixed_row(32'h7FFF_FFFF, 1'b1, 1'b1, 32'h5555_5555, 32'h0, 1'b0));
    // dt counts from time zero: 2000 ms of two full-scale samples overshoots the top
    directed.push_back(fixed_row(32'h7FFF_FFFF, 1'b1, 1'b0, 32'd2000, 32'h7FFF_FFFF, 1'b1));
    // Disabled word holds the output
    directed.push_back(fixed_row(32'h8000_0000, 1'b0, 1'b0, 32'd2100, 32'h7FFF_FFFF, 1'b1));
    // Clear without enable; sample and time of the last word stay as the previous ones
    directed.push_back(fixed_row(32'h8000_0000, 1'b0, 1'b1, 32'd3000, 32'h0, 1'b0));
    directed.push_back(fixed_row(32'h8000_0000, 1'b1, 1'b0, 32'd4100, 32'h8000_0000, 1'b1));
    // Huge dt drives the accumulator into its own negative saturation
    directed.push_back(word_row(32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_FFFF));
    // Time wraps through zero
    directed.push_back(word_row(32'h0001_0000, 1'b1, 1'b0, 32'h0000_0010));
    // Clear with enable: update first, then zero everything
    directed.push_back(fixed_row(32'h0001_0000, 1'b1, 1'b1, 32'h0000_0020, 32'h0, 1'b0));
    // Time unchanged by the clear, so dt is zero here
    directed.push_back(fixed_row(32'h1234_5678, 1'b1, 1'b0, 32'h0000_0010, 32'h0, 1'b0));
    directed.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0011));
    // Tiny negative area floors to minus one
    directed.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0012));
    directed.push_back(word_row(32'h0000_0001, 1'b1, 1'b0, 32'h0000_0013));
    // Limits of plus and minus one with half gain
    directed.push_back(reg_row(RegUpper, 32'h0001_0000));
    directed.push_back(reg_row(RegLower, 32'hFFFF_0000));
    directed.push_back(reg_row(RegGain, 32'h0000_8000));
    directed.push_back(word_row(32'h0002_0000, 1'b1, 1'b0, 32'h0000_0813));
    directed.push_back(word_row(32'hFFFE_0000, 1'b1, 1'b0, 32'h0000_1813));
    directed.push_back(word_row(32'hFFFE_0000, 1'b1, 1'b0, 32'h0000_3813));
    // Largest gain, crossed extreme limits, and a write to the unused index
    directed.push_back(reg_row(RegGain, 32'h7FFF_FFFF));
    directed.push_back(reg_row(RegUpper, 32'h8000_0000));
    directed.push_back(reg_row(RegLower, 32'h7FFF_FFFF));
    directed.push_back(reg_row(RegSpare, 32'hDEAD_BEEF));
    directed.push_back(word_row(32'h7FFF_FFFF, 1'b1, 1'b0, 32'hFFFF_0000));
    directed.push_back(word_row(32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_0001));
    // Most negative gain with crossed narrow limits
    directed.push_back(reg_row(RegGain, 32'h8000_0000));
    directed.push_back(reg_row(RegUpper, 32'hFFF0_0000));
    directed.push_back(reg_row(RegLower, 32'h0010_0000));
    directed.push_back(word_row(32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_0001));
    directed.push_back(word_row(32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_0002));
    // Zero gain adds nothing
    directed.push_back(reg_row(RegGain, 32'h0000_0000));
    directed.push_back(word_row(32'h5555_5555, 1'b1, 1'b0, 32'h7FFF_1000));
    directed.push_back(reg_row(RegGain, GainReset));
    directed.push_back(reg_row(RegUpper, UpperReset));
    directed.push_back(reg_row(RegLower, LowerReset));
    directed.push_back(word_row(32'hAAAA_AAAA, 1'b1, 1'b1, 32'h0000_0000));

    // Hold reset, then release it once
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    idle_odds = 3;
    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        // Registers change only with the block idle
        if (i == 0 || !directed[i-1].is_reg) drain_outputs();
        set_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        push_word(directed[i].word, directed[i].typed, directed[i].want);
      end
    end

    // Random phases, each with its own register setting and idling odds
    t_ms = $urandom;
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_outputs();
      case (ph)
        0: begin
          g = GainReset;
          u = UpperReset;
          l = LowerReset;
        end
        1: begin
          g = 32'h7FFF_FFFF;
          u = UpperReset;
          l = LowerReset;
        end
        2: begin
          g = 32'h8000_0000;
          u = 32'hFFF0_0000;
          l = 32'h0010_0000;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: g = GainReset;
            1: g = $urandom;
            2: begin
              m = $urandom & 32'h0003_FFFF;
              g = $urandom_range(0, 1) ? -m : m;
            end
            default: g = $urandom_range(0, 1) ? 32'h0000_0000 : 32'h0100_0000;
          endcase
          case ($urandom_range(0, 3))
            0: begin
              u = UpperReset;
              l = LowerReset;
            end
            1: begin
              m = ($urandom & 32'h00FF_FFFF) + 32'd1;
              u = m;
              l = -m;
            end
            2: begin
              u = $urandom;
              l = $urandom;
            end
            default: begin
              // Crossed: upper below lower
              m = $urandom & 32'h000F_FFFF;
              u = -m;
              l = m;
            end
          endcase
        end
      endcase
      set_reg(RegGain, g);
      set_reg(RegUpper, u);
      set_reg(RegLower, l);
      // Every third phase and the closing one run with no idling at all
      idle_odds = (ph % 3 == 2 || ph == RandPhases - 1) ? 0 : $urandom_range(2, 6);
      for (int k = 0; k < WordsPerPhase; k++) push_word(next_word(t_ms), 1'b0, '0);
    end

    drain_outputs();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d words and %0d register writes, incl. crossed limits and saturation",
             n_words, n_writes);
    $display("checked %0d output words, %0d of them at a limit", n_checked, n_limited);
    if (n_fail == 0) begin
      $display("limited_trapezoidal_integrator_top regression: pass");
    end else begin
      $display("limited_trapezoidal_integrator_top regression: fail");
    end
    $finish;
  end

  // Watchdog: well past the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("limited_trapezoidal_integrator_top regression: fail");
    $finish;
  end

endmodule
